// ===== rtl/dst_pkg.sv =====
// ---------------------------------------------------------------------------
// dst_pkg: shared types and constants of the drying session timer
//
// Station phases, command codes, register indexes, the queue word that
// travels from the front end to the execute unit, and fixed constants.
// ---------------------------------------------------------------------------
package dst_pkg;

   // default station count and command queue depth
   localparam int STATIONS_DEF = 2;
   localparam int QUEUE_DEPTH  = 2;

   // field widths
   localparam int TIME_W   = 32;
   localparam int SEC_W    = 20;
   localparam int TEMP_W   = 8;
   localparam int Q4_W     = 12;
   localparam int OFFSET_W = 6;
   localparam int CSR_IDX_W = 1;

   // whole seconds in a 32-bit millisecond span fit in 23 bits
   localparam int SECS_W = 23;

   localparam logic [SEC_W-1:0] SEC_MAX       = '1;
   localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;
   localparam logic [9:0]       MS_PER_SEC    = 10'd1000;

   // floor(x / 1000) == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
   localparam logic [28:0] DIV1000_MAGIC = 29'h1062_4DD3;
   localparam int          DIV1000_SHIFT = 38;
   localparam int          DIV_PROD_W    = TIME_W + 29;

   // valid sensor window, -55 to 125 degrees in 1/16 degree
   localparam logic signed [Q4_W-1:0] TEMP_MIN_Q4 = -12'sd880;
   localparam logic signed [Q4_W-1:0] TEMP_MAX_Q4 = 12'sd2000;

   // register reset values
   localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 6'd5;
   localparam logic [TIME_W-1:0]   INTERVAL_RESET = 32'd60000;

   typedef enum logic [1:0] {
      PH_INACTIVE = 2'd0,
      PH_WAITING  = 2'd1,
      PH_DRYING   = 2'd2,
      PH_COMPLETE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_PLAN  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_OFFSET     = 1'b0,
      CSR_PERSIST_INTERVAL = 1'b1
   } csr_index_type;

   // classified command word held in the queue
   typedef struct packed {
      op_type                 op;
      logic                   station;
      logic                   load_ok;
      logic [TEMP_W-1:0]      dry_temp_c;
      logic [SEC_W-1:0]       load_secs;
      logic [TIME_W-1:0]      now_ms;
      logic signed [Q4_W-1:0] chamber_temp_q4;
      logic                   sensor_present;
      logic                   plan_usable;
      logic                   plan_ok;
      logic [TEMP_W-1:0]      plan_target_c;
      logic                   clock_synced;
      logic [TIME_W-1:0]      epoch_now;
   } cmd_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] start_offset_c;
      logic [TIME_W-1:0]   persist_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/dst_ifs.sv =====
// ---------------------------------------------------------------------------
// dst channel interfaces
//
// Command, result and register write channels, each with valid/ready.
// ---------------------------------------------------------------------------
interface dst_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              command;
   logic                                    station;
   logic                                    profile_found;
   logic [dst_pkg::TEMP_W-1:0]              dry_temp_c;
   logic [7:0]                              dry_time_hours;
   logic [dst_pkg::TIME_W-1:0]              now_ms;
   logic signed [dst_pkg::Q4_W-1:0]         chamber_temp_q4;
   logic                                    sensor_present;
   logic                                    plan_usable;
   logic [dst_pkg::TEMP_W-1:0]              plan_target_c;
   logic                                    clock_synced;
   logic [dst_pkg::TIME_W-1:0]              epoch_now;

   modport source (
      output valid, command, station, profile_found, dry_temp_c, dry_time_hours,
             now_ms, chamber_temp_q4, sensor_present, plan_usable, plan_target_c,
             clock_synced, epoch_now,
      input  ready
   );
   modport sink (
      input  valid, command, station, profile_found, dry_temp_c, dry_time_hours,
             now_ms, chamber_temp_q4, sensor_present, plan_usable, plan_target_c,
             clock_synced, epoch_now,
      output ready
   );
endinterface

interface dst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          out_station;
   logic [1:0]                    session_state;
   logic                          occupied;
   logic [dst_pkg::SEC_W-1:0]     remaining_seconds;
   logic [dst_pkg::TIME_W-1:0]    finish_epoch;
   logic [dst_pkg::TEMP_W-1:0]    threshold_c;
   logic                          save_request;
   logic                          last_result;

   modport source (
      output valid, out_station, session_state, occupied, remaining_seconds,
             finish_epoch, threshold_c, save_request, last_result,
      input  ready
   );
   modport sink (
      input  valid, out_station, session_state, occupied, remaining_seconds,
             finish_epoch, threshold_c, save_request, last_result,
      output ready
   );
endinterface

interface dst_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dst_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [dst_pkg::TIME_W-1:0]       wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/drying_session_timer.sv =====
// ---------------------------------------------------------------------------
// drying_session_timer: per-station drying session timer
//
// Tracks load, start, countdown, completion and save requests for a set of
// spool stations, driven by load, tick, clear and plan command words.
// ---------------------------------------------------------------------------
// Each command word is taken into a two-entry queue in the cycle it arrives
// and then runs through the execute sequencer (time differences, divide by
// 1000 on a reciprocal multiplier, scale back to milliseconds, record
// write-back); the sequencer takes the next word from the queue in the cycle
// the last write-back of a word goes out, and a write-back waits while the
// result register still holds an unread result. A plan word writes back once
// for each station. Results wait in an output register while new words keep
// filling the queue. Load, tick and clear give one result for the addressed
// station, plan gives one per station from station 0, and a word for a
// station that does not exist is taken and dropped. Registers should be
// written only while no word is in flight.
module drying_session_timer #(
   parameter int STATIONS = dst_pkg::STATIONS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dst_req_if.sink   req_bus,
   dst_rsp_if.source rsp_bus,
   dst_csr_if.sink   csr_bus
);

   logic [dst_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [dst_pkg::TIME_W-1:0]   interval_ff, interval_in;
   dst_pkg::cfg_type             cfg;
   dst_pkg::q_status_type        q_status;
   dst_pkg::cmd_type             push_word;
   dst_pkg::cmd_type             head_word;
   logic                         push;
   logic                         pop;

   // register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_comb begin
      offset_in   = offset_ff;
      interval_in = interval_ff;
      if (csr_bus.valid) begin
         unique case (dst_pkg::csr_index_type'(csr_bus.reg_index))
            dst_pkg::CSR_START_OFFSET:
               offset_in = csr_bus.wdata[dst_pkg::OFFSET_W-1:0];
            dst_pkg::CSR_PERSIST_INTERVAL:
               interval_in = csr_bus.wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= dst_pkg::OFFSET_RESET;
         interval_ff <= dst_pkg::INTERVAL_RESET;
      end else begin
         offset_ff   <= offset_in;
         interval_ff <= interval_in;
      end
   end

   assign cfg.start_offset_c      = offset_ff;
   assign cfg.persist_interval_ms = interval_ff;

   dst_front #(
      .STATIONS (STATIONS)
   ) u_front (
      .req       (req_bus),
      .q_status  (q_status),
      .push      (push),
      .push_word (push_word)
   );

   dst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .status    (q_status)
   );

   dst_exec #(
      .STATIONS (STATIONS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_status  (q_status),
      .head_word (head_word),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

// ===== rtl/dst_queue.sv =====
// ---------------------------------------------------------------------------
// dst_queue: command queue between front end and execute unit
//
// Small register FIFO of classified command words.
// ---------------------------------------------------------------------------
module dst_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dst_pkg::cmd_type      push_word,
   input  logic                  pop,
   output dst_pkg::cmd_type      head_word,
   output dst_pkg::q_status_type status
);

   localparam int DEPTH = dst_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dst_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_word    = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/dst_front.sv =====
// ---------------------------------------------------------------------------
// dst_front: command front end
//
// Accepts command words, drops words for stations that do not exist, and
// classifies the rest (profile check, session length, plan target) into a
// queue word.
// ---------------------------------------------------------------------------
module dst_front #(
   parameter int STATIONS = dst_pkg::STATIONS_DEF
) (
   dst_req_if.sink                      req,
   input  dst_pkg::q_status_type        q_status,
   output logic                         push,
   output dst_pkg::cmd_type             push_word
);

   localparam logic STATION1_OK = (STATIONS > 1);

   logic in_range;
   logic is_plan;

   // take a word whenever the queue has room
   assign req.ready = !q_status.full;

   // plan words address every station; others need a real station
   assign is_plan  = (dst_pkg::op_type'(req.command) == dst_pkg::OP_PLAN);
   assign in_range = is_plan || !req.station || STATION1_OK;
   assign push     = req.valid && req.ready && in_range;

   // classify the word
   always_comb begin
      push_word.op              = dst_pkg::op_type'(req.command);
      push_word.station         = req.station;
      push_word.load_ok         = req.profile_found && (req.dry_temp_c != '0)
                                  && (req.dry_time_hours != '0);
      push_word.dry_temp_c      = req.dry_temp_c;
      push_word.load_secs       = dst_pkg::SEC_W'(req.dry_time_hours)
                                  * dst_pkg::SEC_W'(dst_pkg::SECS_PER_HOUR);
      push_word.now_ms          = req.now_ms;
      push_word.chamber_temp_q4 = req.chamber_temp_q4;
      push_word.sensor_present  = req.sensor_present;
      push_word.plan_usable     = req.plan_usable;
      push_word.plan_ok         = req.plan_usable && (req.plan_target_c != '0);
      push_word.plan_target_c   = req.plan_target_c;
      push_word.clock_synced    = req.clock_synced;
      push_word.epoch_now       = req.epoch_now;
   end

endmodule

// ===== rtl/dst_exec.sv =====
// ---------------------------------------------------------------------------
// dst_exec: station execute unit
//
// Holds the per-station session records and runs one queue word at a time
// through a short sequencer: time differences, divide by 1000 through a
// reciprocal multiply, scale back to milliseconds, then update the record
// and load the result register. Plan words write back once per station.
// ---------------------------------------------------------------------------
module dst_exec #(
   parameter int STATIONS = dst_pkg::STATIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dst_pkg::cfg_type      cfg,
   input  dst_pkg::q_status_type q_status,
   input  dst_pkg::cmd_type      head_word,
   output logic                  pop,
   dst_rsp_if.source             rsp
);

   localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;
   localparam int CNT_W = $clog2(STATIONS + 1);
   localparam int SEC_W = dst_pkg::SEC_W;
   localparam int TIME_W = dst_pkg::TIME_W;
   localparam int TEMP_W = dst_pkg::TEMP_W;

   typedef enum logic [4:0] {
      SEQ_IDLE  = 5'b00001,
      SEQ_DIFF  = 5'b00010,
      SEQ_DIV   = 5'b00100,
      SEQ_SCALE = 5'b01000,
      SEQ_WB    = 5'b10000
   } seq_type;

   typedef struct packed {
      logic                  out_station;
      dst_pkg::phase_type    session_state;
      logic                  occupied;
      logic [SEC_W-1:0]      remaining_seconds;
      logic [TIME_W-1:0]     finish_epoch;
      logic [TEMP_W-1:0]     threshold_c;
      logic                  save_request;
      logic                  last_result;
   } rsp_word_type;

   // station records
   dst_pkg::phase_type  phase_ff    [STATIONS];
   logic [STATIONS-1:0] spool_ff;
   logic [TEMP_W-1:0]   ptemp_ff    [STATIONS];
   logic [SEC_W-1:0]    secleft_ff  [STATIONS];
   logic [TEMP_W-1:0]   thr_ff      [STATIONS];
   logic [TIME_W-1:0]   deadline_ff [STATIONS];
   logic [TIME_W-1:0]   tick_ff     [STATIONS];
   logic [TIME_W-1:0]   saved_ff    [STATIONS];

   // sequencer and work registers
   seq_type                      seq_ff, seq_in;
   dst_pkg::cmd_type             cmd_ff;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [TIME_W-1:0]            elapsed_ff;
   logic [TIME_W-1:0]            esum_ff;
   logic [TIME_W-1:0]            since_save_ff;
   logic [dst_pkg::SECS_W-1:0]   secs_ff;
   logic [TIME_W-1:0]            dl_ff;
   logic [TIME_W-1:0]            back_ms_ff;
   logic [TIME_W-1:0]            epoch_diff_ff;
   logic                         past_ff;
   logic                         save_due_ff;
   logic                         rsp_valid_ff;
   rsp_word_type                 rsp_ff, rsp_in;

   // current record at the selected station
   dst_pkg::phase_type  cur_phase;
   logic                cur_spool;
   logic [TEMP_W-1:0]   cur_ptemp;
   logic [SEC_W-1:0]    cur_secleft;
   logic [TEMP_W-1:0]   cur_thr;
   logic [TIME_W-1:0]   cur_deadline;
   logic [TIME_W-1:0]   cur_tick;
   logic [TIME_W-1:0]   cur_saved;

   // next record
   dst_pkg::phase_type  phase_in;
   logic                spool_in;
   logic [TEMP_W-1:0]   ptemp_in;
   logic [SEC_W-1:0]    secleft_in;
   logic [TEMP_W-1:0]   thr_in;
   logic [TIME_W-1:0]   deadline_in;
   logic [TIME_W-1:0]   tick_in;
   logic [TIME_W-1:0]   saved_in;
   logic                save_flag;
   logic                finish;

   logic                          emit_go;
   logic                          idx_last;
   logic                          item_done;
   logic [dst_pkg::DIV_PROD_W-1:0] div_prod;
   logic [CNT_W-1:0]              spool_cnt;
   logic [TEMP_W-1:0]             load_thr;
   logic [TEMP_W-1:0]             plan_thr;
   logic [TEMP_W-1:0]             target;
   logic [TEMP_W:0]               upper;
   logic signed [13:0]            q14;
   logic signed [13:0]            thr16;
   logic signed [13:0]            upper16;
   logic                          in_window;
   logic                          start_blocked;

   function automatic logic [TEMP_W-1:0] floor_thr(
      input logic [TEMP_W-1:0]            temp,
      input logic [dst_pkg::OFFSET_W-1:0] offset
   );
      logic [TEMP_W-1:0] off8;
      off8 = TEMP_W'(offset);
      floor_thr = (temp > off8) ? temp - off8 : '0;
   endfunction

   assign cur_phase    = phase_ff[idx_ff];
   assign cur_spool    = spool_ff[idx_ff];
   assign cur_ptemp    = ptemp_ff[idx_ff];
   assign cur_secleft  = secleft_ff[idx_ff];
   assign cur_thr      = thr_ff[idx_ff];
   assign cur_deadline = deadline_ff[idx_ff];
   assign cur_tick     = tick_ff[idx_ff];
   assign cur_saved    = saved_ff[idx_ff];

   // ---- sequencer ----
   assign emit_go   = (seq_ff == SEQ_WB) && (!rsp_valid_ff || rsp.ready);
   assign idx_last  = (idx_ff == IDX_W'(STATIONS - 1));
   assign item_done = emit_go && ((cmd_ff.op != dst_pkg::OP_PLAN) || idx_last);
   assign pop       = !q_status.empty && ((seq_ff == SEQ_IDLE) || item_done);

   always_comb begin
      unique case (seq_ff)
         SEQ_IDLE:  seq_in = pop ? SEQ_DIFF : SEQ_IDLE;
         SEQ_DIFF:  seq_in = SEQ_DIV;
         SEQ_DIV:   seq_in = SEQ_SCALE;
         SEQ_SCALE: seq_in = SEQ_WB;
         SEQ_WB: begin
            if (item_done) begin
               seq_in = pop ? SEQ_DIFF : SEQ_IDLE;
            end else begin
               seq_in = SEQ_WB;
            end
         end
         default:   seq_in = SEQ_IDLE;
      endcase
   end

   // select the station: addressed one, or sweep from station 0 for a plan
   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = (head_word.op == dst_pkg::OP_PLAN) ? '0 : IDX_W'(head_word.station);
      end else if (emit_go && (cmd_ff.op == dst_pkg::OP_PLAN) && !idx_last) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         idx_ff <= '0;
      end else begin
         seq_ff <= seq_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_word;
      end
   end

   // ---- arithmetic pipeline; inputs hold steady from DIFF through WB ----
   assign div_prod = dst_pkg::DIV_PROD_W'(elapsed_ff)
                     * dst_pkg::DIV_PROD_W'(dst_pkg::DIV1000_MAGIC);

   always_ff @(posedge clock) begin
      // time differences
      elapsed_ff    <= cmd_ff.now_ms - cur_tick;
      esum_ff       <= cmd_ff.epoch_now + TIME_W'(cur_secleft);
      since_save_ff <= cmd_ff.now_ms - cur_saved;
      // whole seconds and effective deadline
      secs_ff       <= div_prod[dst_pkg::DIV1000_SHIFT +: dst_pkg::SECS_W];
      dl_ff         <= (cur_deadline == '0) ? esum_ff : cur_deadline;
      // scale back, deadline distance, save interval check
      back_ms_ff    <= TIME_W'(secs_ff) * TIME_W'(dst_pkg::MS_PER_SEC);
      epoch_diff_ff <= dl_ff - cmd_ff.epoch_now;
      past_ff       <= (cmd_ff.epoch_now >= dl_ff);
      save_due_ff   <= (since_save_ff >= cfg.persist_interval_ms);
   end

   // ---- start window ----
   always_comb begin
      spool_cnt = '0;
      for (int i = 0; i < STATIONS; i++) begin
         spool_cnt = spool_cnt + CNT_W'(spool_ff[i]);
      end
   end

   assign load_thr      = floor_thr(cmd_ff.dry_temp_c, cfg.start_offset_c);
   assign plan_thr      = floor_thr(cmd_ff.plan_target_c, cfg.start_offset_c);
   assign target        = cmd_ff.plan_ok ? cmd_ff.plan_target_c : cur_ptemp;
   assign upper         = {1'b0, target} + (TEMP_W + 1)'(cfg.start_offset_c);
   assign q14           = 14'(cmd_ff.chamber_temp_q4);
   assign thr16         = $signed({2'b00, cur_thr, 4'b0000});
   assign upper16       = $signed({1'b0, upper, 4'b0000});
   assign start_blocked = (spool_cnt > CNT_W'(1)) && !cmd_ff.plan_usable;
   assign in_window     = cmd_ff.sensor_present
                          && (cmd_ff.chamber_temp_q4 >= dst_pkg::TEMP_MIN_Q4)
                          && (cmd_ff.chamber_temp_q4 <= dst_pkg::TEMP_MAX_Q4)
                          && (q14 >= thr16) && (q14 <= upper16);

   // ---- record update ----
   always_comb begin
      phase_in    = cur_phase;
      spool_in    = cur_spool;
      ptemp_in    = cur_ptemp;
      secleft_in  = cur_secleft;
      thr_in      = cur_thr;
      deadline_in = cur_deadline;
      tick_in     = cur_tick;
      saved_in    = cur_saved;
      save_flag   = 1'b0;
      finish      = 1'b0;

      unique case (cmd_ff.op)
         dst_pkg::OP_LOAD: begin
            phase_in    = dst_pkg::PH_INACTIVE;
            spool_in    = 1'b1;
            ptemp_in    = cmd_ff.dry_temp_c;
            secleft_in  = '0;
            thr_in      = '0;
            deadline_in = '0;
            tick_in     = '0;
            saved_in    = cmd_ff.now_ms;
            save_flag   = 1'b1;
            if (cmd_ff.load_ok) begin
               secleft_in = cmd_ff.load_secs;
               thr_in     = load_thr;
               phase_in   = dst_pkg::PH_WAITING;
            end
         end
         dst_pkg::OP_CLEAR: begin
            phase_in    = dst_pkg::PH_INACTIVE;
            spool_in    = 1'b0;
            ptemp_in    = '0;
            secleft_in  = '0;
            thr_in      = '0;
            deadline_in = '0;
            tick_in     = '0;
            saved_in    = '0;
         end
         dst_pkg::OP_PLAN: begin
            if (cmd_ff.plan_ok && (cur_phase == dst_pkg::PH_WAITING)
                && (cur_thr != plan_thr)) begin
               thr_in    = plan_thr;
               saved_in  = cmd_ff.now_ms;
               save_flag = 1'b1;
            end
         end
         dst_pkg::OP_TICK: begin
            if (cur_phase == dst_pkg::PH_WAITING) begin
               // start drying once the chamber is in the window and the start is not blocked
               if (!start_blocked && in_window) begin
                  phase_in    = dst_pkg::PH_DRYING;
                  tick_in     = cmd_ff.now_ms;
                  deadline_in = cmd_ff.clock_synced ? esum_ff : '0;
                  saved_in    = cmd_ff.now_ms;
                  save_flag   = 1'b1;
               end
            end else if (cur_phase == dst_pkg::PH_DRYING) begin
               if (cur_secleft == '0) begin
                  finish = 1'b1;
               end else if (cmd_ff.clock_synced) begin
                  // count against the epoch deadline
                  if (past_ff) begin
                     finish = 1'b1;
                  end else begin
                     deadline_in = dl_ff;
                     secleft_in  = (|epoch_diff_ff[TIME_W-1:SEC_W]) ? dst_pkg::SEC_MAX
                                                                    : epoch_diff_ff[SEC_W-1:0];
                     tick_in     = cmd_ff.now_ms;
                     if ((cur_deadline == '0) || save_due_ff) begin
                        saved_in  = cmd_ff.now_ms;
                        save_flag = 1'b1;
                     end
                  end
               end else if (secs_ff != '0) begin
                  // count whole elapsed seconds of the millisecond clock
                  tick_in = cur_tick + back_ms_ff;
                  if (secs_ff >= dst_pkg::SECS_W'(cur_secleft)) begin
                     finish = 1'b1;
                  end else begin
                     secleft_in = cur_secleft - SEC_W'(secs_ff);
                     if (save_due_ff) begin
                        saved_in  = cmd_ff.now_ms;
                        save_flag = 1'b1;
                     end
                  end
               end
            end
         end
      endcase

      // close out the session
      if (finish) begin
         secleft_in  = '0;
         deadline_in = '0;
         phase_in    = dst_pkg::PH_COMPLETE;
         saved_in    = cmd_ff.now_ms;
         save_flag   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spool_ff <= '0;
         for (int i = 0; i < STATIONS; i++) begin
            phase_ff[i]    <= dst_pkg::PH_INACTIVE;
            ptemp_ff[i]    <= '0;
            secleft_ff[i]  <= '0;
            thr_ff[i]      <= '0;
            deadline_ff[i] <= '0;
            tick_ff[i]     <= '0;
            saved_ff[i]    <= '0;
         end
      end else if (emit_go) begin
         phase_ff[idx_ff]    <= phase_in;
         spool_ff[idx_ff]    <= spool_in;
         ptemp_ff[idx_ff]    <= ptemp_in;
         secleft_ff[idx_ff]  <= secleft_in;
         thr_ff[idx_ff]      <= thr_in;
         deadline_ff[idx_ff] <= deadline_in;
         tick_ff[idx_ff]     <= tick_in;
         saved_ff[idx_ff]    <= saved_in;
      end
   end

   // ---- result register ----
   always_comb begin
      rsp_in.out_station       = idx_ff[0];
      rsp_in.session_state     = phase_in;
      rsp_in.occupied          = spool_in;
      rsp_in.remaining_seconds = secleft_in;
      rsp_in.finish_epoch      = deadline_in;
      rsp_in.threshold_c       = thr_in;
      rsp_in.save_request      = save_flag;
      rsp_in.last_result       = (cmd_ff.op != dst_pkg::OP_PLAN) || idx_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.out_station       = rsp_ff.out_station;
   assign rsp.session_state     = rsp_ff.session_state;
   assign rsp.occupied          = rsp_ff.occupied;
   assign rsp.remaining_seconds = rsp_ff.remaining_seconds;
   assign rsp.finish_epoch      = rsp_ff.finish_epoch;
   assign rsp.threshold_c       = rsp_ff.threshold_c;
   assign rsp.save_request      = rsp_ff.save_request;
   assign rsp.last_result       = rsp_ff.last_result;

`ifndef NO_ASSERTIONS
   // a plan sweep keeps writing back until its last station
   a_plan_sweep: assert property (@(posedge clock) disable iff (reset)
      (emit_go && !item_done) |=> (seq_ff == SEQ_WB))
      else $error("plan sweep left write-back early");

   // an inactive station carries no time, deadline or threshold
   a_inactive_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.session_state == dst_pkg::PH_INACTIVE))
      |-> ((rsp_ff.remaining_seconds == '0) && (rsp_ff.finish_epoch == '0)
           && (rsp_ff.threshold_c == '0)))
      else $error("inactive station reported with leftover session data");

   // a live session always belongs to an occupied station
   a_live_occupied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_ff.session_state == dst_pkg::PH_WAITING)
                        || (rsp_ff.session_state == dst_pkg::PH_DRYING)))
      |-> rsp_ff.occupied)
      else $error("live session on an empty station");
`endif

endmodule
